### rtl/orb_pkg.sv
// ----------------------------------------------------------------------------
// Overwriting ring buffer package
// Shared transaction types and operation codes for the ring buffer block.
// ----------------------------------------------------------------------------
`default_nettype none

package orb_pkg;

   // Operation codes carried in the request transaction.
   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_LIST   = 2'd2;

   // Fixed field widths of the transactions.
   localparam int unsigned OP_BITS    = 2;
   localparam int unsigned WORD_BITS  = 64;
   localparam int unsigned COUNT_BITS = 5;

   // Request transaction.
   typedef struct packed {
      logic [OP_BITS-1:0]    op;
      logic [WORD_BITS-1:0]  element;
      logic [COUNT_BITS-1:0] remove_count;
   } orb_req_type;

   // Response transaction, one per listed element.
   typedef struct packed {
      logic [WORD_BITS-1:0] listed_element;
      logic                 last;
   } orb_rsp_type;

   // Sequencer states.
   typedef enum logic {
      ST_IDLE,
      ST_LIST
   } orb_state_type;

endpackage

`default_nettype wire

### rtl/orb_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module orb_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/overwriting_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// Overwriting ring buffer unit
// Ring buffer of data words that overwrites its oldest word when full.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction is taken at a clock edge where start is high and
//   busy is low. An append stores one word as the newest; when the buffer is
//   full the oldest word is overwritten. A remove drops remove_count oldest
//   words and clamps at empty. Both give no response and leave busy low, so
//   they can be issued on every cycle while busy is low.
//   A list reads the slot memory once per cycle from oldest to newest. Each
//   word appears on rsp for exactly one cycle with rsp_valid high, the first
//   one in the cycle after the list is taken; the newest word carries last. A list
//   keeps busy high until the read of the newest word is issued, limited by
//   the one read port of the slot memory. A list of an empty buffer gives
//   no response. The receiver cannot stall; responses are never held back.
//   Writing csr_wdata with csr_we sets the capacity (zero reads as one,
//   values above DEPTH saturate) and empties the buffer. Write it only while
//   the unit is idle.
//   Reset sets the capacity to 16 (limited to DEPTH) and empties the buffer.
//   The slot memory has no reset; only written slots are ever listed.
// ----------------------------------------------------------------------------
`default_nettype none

module overwriting_ring_buffer_unit
   import orb_pkg::*;
#(
   parameter int unsigned DEPTH     = 16,
   parameter int unsigned ELEM_BITS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire orb_req_type           req,
   output logic                       rsp_valid,
   output orb_rsp_type                rsp,
   input  wire logic                  csr_we,
   input  wire logic [COUNT_BITS-1:0] csr_wdata
);

   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned RESET_CAP = (DEPTH < 16) ? DEPTH : 16;

   // Index after idx in a ring of cap slots.
   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(idx) + (CNT_W+1)'(1);
      return (sum >= (CNT_W+1)'(cap)) ? '0 : IDX_W'(sum);
   endfunction

   // Control state.
   orb_state_type    state_ff,  state_in;
   logic [CNT_W-1:0] cap_ff,    cap_in;
   logic [IDX_W-1:0] oldest_ff, oldest_in;
   logic [IDX_W-1:0] newest_ff, newest_in;
   logic [CNT_W-1:0] fill_ff,   fill_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic             rd_valid_ff, rd_valid_in;
   logic             rd_last_ff,  rd_last_in;

   // Memory port signals.
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [ELEM_BITS-1:0] ram_wr_data;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic [ELEM_BITS-1:0] ram_rd_data;

   // Helpers for the request decode.
   logic             accept;
   logic [CNT_W-1:0] cap_wr;
   logic [CNT_W-1:0] remove_k;
   logic [CNT_W-1:0] fill_left;
   logic [CNT_W:0]   oldest_sum;

   assign accept = start && !busy;
   assign busy   = (state_ff == ST_LIST);

   // Effective capacity of a register write.
   always_comb begin
      if (csr_wdata == '0) begin
         cap_wr = CNT_W'(1);
      end else if (32'(csr_wdata) > DEPTH) begin
         cap_wr = CNT_W'(DEPTH);
      end else begin
         cap_wr = CNT_W'(csr_wdata);
      end
   end

   // Remove arithmetic: clamp the count and advance the oldest index.
   always_comb begin
      if (32'(req.remove_count) > 32'(fill_ff)) begin
         remove_k = fill_ff;
      end else begin
         remove_k = CNT_W'(req.remove_count);
      end
      fill_left  = fill_ff - remove_k;
      oldest_sum = (CNT_W+1)'(oldest_ff) + (CNT_W+1)'(remove_k);
      if (oldest_sum >= (CNT_W+1)'(cap_ff)) begin
         oldest_sum = oldest_sum - (CNT_W+1)'(cap_ff);
      end
   end

   // Next state, pointer updates and memory access.
   always_comb begin
      state_in    = state_ff;
      cap_in      = cap_ff;
      oldest_in   = oldest_ff;
      newest_in   = newest_ff;
      fill_in     = fill_ff;
      rd_idx_in   = rd_idx_ff;
      remain_in   = remain_ff;
      rd_valid_in = 1'b0;
      rd_last_in  = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = next_idx(newest_ff, cap_ff);
      ram_wr_data = req.element[ELEM_BITS-1:0];
      ram_rd_addr = oldest_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_we) begin
               cap_in    = cap_wr;
               oldest_in = '0;
               newest_in = IDX_W'(cap_wr - CNT_W'(1));
               fill_in   = '0;
            end else if (accept) begin
               case (req.op)
                  OP_APPEND: begin
                     if (fill_ff >= cap_ff) begin
                        oldest_in = next_idx(oldest_ff, cap_ff);
                     end else begin
                        fill_in = fill_ff + CNT_W'(1);
                     end
                     newest_in = next_idx(newest_ff, cap_ff);
                     ram_wr_en = 1'b1;
                  end
                  OP_REMOVE: begin
                     fill_in = fill_left;
                     if (fill_left == '0) begin
                        oldest_in = '0;
                        newest_in = IDX_W'(cap_ff - CNT_W'(1));
                     end else begin
                        oldest_in = IDX_W'(oldest_sum);
                     end
                  end
                  OP_LIST: begin
                     if (fill_ff != '0) begin
                        rd_valid_in = 1'b1;
                        rd_last_in  = (fill_ff == CNT_W'(1));
                        rd_idx_in   = next_idx(oldest_ff, cap_ff);
                        remain_in   = fill_ff - CNT_W'(1);
                        if (fill_ff != CNT_W'(1)) begin
                           state_in = ST_LIST;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LIST: begin
            // One read per cycle until the newest word has been read.
            ram_rd_addr = rd_idx_ff;
            rd_valid_in = 1'b1;
            rd_last_in  = (remain_ff == CNT_W'(1));
            rd_idx_in   = next_idx(rd_idx_ff, cap_ff);
            remain_in   = remain_ff - CNT_W'(1);
            if (remain_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cap_ff      <= CNT_W'(RESET_CAP);
         oldest_ff   <= '0;
         newest_ff   <= IDX_W'(RESET_CAP - 1);
         fill_ff     <= '0;
         rd_idx_ff   <= '0;
         remain_ff   <= '0;
         rd_valid_ff <= 1'b0;
         rd_last_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cap_ff      <= cap_in;
         oldest_ff   <= oldest_in;
         newest_ff   <= newest_in;
         fill_ff     <= fill_in;
         rd_idx_ff   <= rd_idx_in;
         remain_ff   <= remain_in;
         rd_valid_ff <= rd_valid_in;
         rd_last_ff  <= rd_last_in;
      end
   end

   // Slot storage.
   orb_ram #(
      .WIDTH (ELEM_BITS),
      .DEPTH (DEPTH),
      .AW    (IDX_W)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Response transaction is driven from the registered read data and the registered valid and last flags.
   assign rsp_valid           = rd_valid_ff;
   assign rsp.listed_element  = WORD_BITS'(ram_rd_data);
   assign rsp.last            = rd_last_ff;

   // The fill level never exceeds the capacity in use.
   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cap_ff)
      else $error("fill level above capacity");

   // A response only follows a list taken or running in the previous cycle.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || (start && req.op == OP_LIST)))
      else $error("response without a list in progress");

   // While listing, some words remain to be read, fewer than are held, and the contents do not change.
   a_list_remain: assert property (@(posedge clock) disable iff (reset)
      busy |-> (remain_ff != '0) && (remain_ff < fill_ff))
      else $error("list run count out of range");

   // A run that is still listing has not emitted its last word.
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      $past(busy) && busy |-> !(rsp_valid && rsp.last))
      else $error("last marker inside a list run");

endmodule

`default_nettype wire
